@@ hw/rtl/d2d_pkg.sv @@
// shared types and constants for the disparity to depth pixel core
`timescale 1ns / 1ps

package d2d_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned D80_W   = 20;
  localparam int unsigned MDISP_W = 16;
  localparam int unsigned OFS_W   = 20;
  localparam int unsigned BIAS_W  = 21;
  localparam int unsigned DEN_W   = 21;
  localparam int unsigned FB_W    = 32;
  localparam int unsigned MD_W    = 32;
  localparam int unsigned NUM_W   = 39;
  localparam int unsigned DIVD_W  = 49;
  localparam int unsigned PROD_W  = MD_W + DEN_W;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CDATA_W = 32;

  localparam logic [MDISP_W-1:0] DISP_HIGH_MAX = 16'd950;
  localparam logic [D80_W-1:0]   UNITS_8BIT    = 20'd80;
  localparam logic [D80_W-1:0]   UNITS_8BIT_HI = 20'd8;
  localparam logic [D80_W-1:0]   UNITS_16BIT   = 20'd10;
  localparam logic [NUM_W-1:0]   UNITS_NUM     = 39'd80;
  localparam logic [DIVD_W-1:0]  UNITS_MM      = 49'd80000;
  localparam logic [VAL_W-1:0]   MM_SAT        = 32'h0000_FFFF;

  localparam logic [MDISP_W-1:0] RST_MAX_DISP  = 16'd95;
  localparam logic [MD_W-1:0]    RST_MAX_DEPTH = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REG_DISP_FMT   = 3'd0,
    REG_MAX_DISP   = 3'd1,
    REG_DRV_OFS    = 3'd2,
    REG_BIAS       = 3'd3,
    REG_FOCAL_BL   = 3'd4,
    REG_MAX_DEPTH  = 3'd5,
    REG_IGN_ZERO   = 3'd6,
    REG_DEPTH_FMT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               disp_fmt;
    logic [MDISP_W-1:0] max_disp;
    logic [OFS_W-1:0]   drv_ofs;
    logic [BIAS_W-1:0]  bias;
    logic [FB_W-1:0]    focal_bl;
    logic [MD_W-1:0]    max_depth;
    logic               ign_zero;
    logic               depth_fmt;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    disp_fmt:  1'b0,
    max_disp:  RST_MAX_DISP,
    drv_ofs:   '0,
    bias:      '0,
    focal_bl:  '0,
    max_depth: RST_MAX_DEPTH,
    ign_zero:  1'b0,
    depth_fmt: 1'b0
  };

  typedef struct packed {
    logic             ok;
    logic             ovf;
    logic [DEN_W-1:0] uden;
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   dq;
  } div_item_t;

endpackage

@@ hw/rtl/d2d_cfg_regs.sv @@
// configuration register file
`timescale 1ns / 1ps

module d2d_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [d2d_pkg::CDATA_W-1:0]  cfg_data,
  output d2d_pkg::cfg_t                cfg
);

  d2d_pkg::cfg_t cfg_r;
  d2d_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (d2d_pkg::reg_idx_t'(cfg_index))
        d2d_pkg::REG_DISP_FMT:  cfg_nxt.disp_fmt  = cfg_data[0];
        d2d_pkg::REG_MAX_DISP:  cfg_nxt.max_disp  = cfg_data[d2d_pkg::MDISP_W-1:0];
        d2d_pkg::REG_DRV_OFS:   cfg_nxt.drv_ofs   = cfg_data[d2d_pkg::OFS_W-1:0];
        d2d_pkg::REG_BIAS:      cfg_nxt.bias      = cfg_data[d2d_pkg::BIAS_W-1:0];
        d2d_pkg::REG_FOCAL_BL:  cfg_nxt.focal_bl  = cfg_data[d2d_pkg::FB_W-1:0];
        d2d_pkg::REG_MAX_DEPTH: cfg_nxt.max_depth = cfg_data[d2d_pkg::MD_W-1:0];
        d2d_pkg::REG_IGN_ZERO:  cfg_nxt.ign_zero  = cfg_data[0];
        d2d_pkg::REG_DEPTH_FMT: cfg_nxt.depth_fmt = cfg_data[0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= d2d_pkg::CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/d2d_front.sv @@
// front stages: scaling, offset removal, denominator, depth limit check
`timescale 1ns / 1ps

module d2d_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  d2d_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  logic [d2d_pkg::RAW_W-1:0]   in_raw,
  output logic                        div_valid,
  output d2d_pkg::div_item_t          div_item
);

  // stage a
  logic                        a_v_r;
  logic [d2d_pkg::D80_W-1:0]   a_d80_r;
  logic [d2d_pkg::D80_W-1:0]   a_d80_nxt;
  // stage b
  logic                        b_v_r;
  logic                        b_ok_r;
  logic                        b_ok_nxt;
  logic [d2d_pkg::DEN_W-1:0]   b_uden_r;
  logic [d2d_pkg::NUM_W-1:0]   b_num_r;
  logic [d2d_pkg::DIVD_W-1:0]  b_divd_r;
  logic [d2d_pkg::D80_W-1:0]   d_clamp;
  logic signed [d2d_pkg::DEN_W:0] den;
  // stage c
  logic                        c_v_r;
  logic                        c_ok_r;
  logic [d2d_pkg::DEN_W-1:0]   c_uden_r;
  logic [d2d_pkg::NUM_W-1:0]   c_num_r;
  logic [d2d_pkg::DIVD_W-1:0]  c_divd_r;
  logic [d2d_pkg::PROD_W-1:0]  c_prod_r;
  // stage d
  logic                        d_v_r;
  d2d_pkg::div_item_t          d_item_r;
  d2d_pkg::div_item_t          d_item_nxt;
  logic                        big;

  assign big = cfg.max_disp > d2d_pkg::DISP_HIGH_MAX;

  // dividing by ten is folded into the scale factor
  always_comb begin
    unique case ({cfg.disp_fmt, big})
      2'b00:   a_d80_nxt = d2d_pkg::D80_W'(in_raw[7:0]) * d2d_pkg::UNITS_8BIT;
      2'b01:   a_d80_nxt = d2d_pkg::D80_W'(in_raw[7:0]) * d2d_pkg::UNITS_8BIT_HI;
      2'b10:   a_d80_nxt = d2d_pkg::D80_W'(in_raw) * d2d_pkg::UNITS_16BIT;
      default: a_d80_nxt = d2d_pkg::D80_W'(in_raw);
    endcase
  end

  always_comb begin
    d_clamp  = (a_d80_r < cfg.drv_ofs) ? '0 : a_d80_r - cfg.drv_ofs;
    den      = $signed({2'b00, d_clamp}) + $signed({cfg.bias[d2d_pkg::BIAS_W-1], cfg.bias});
    b_ok_nxt = !den[d2d_pkg::DEN_W] && (den != '0) && !(cfg.ign_zero && (d_clamp == '0));
  end

  always_comb begin
    d_item_nxt.ok   = c_ok_r && !({{(d2d_pkg::PROD_W-d2d_pkg::NUM_W){1'b0}}, c_num_r} > c_prod_r);
    d_item_nxt.ovf  = {4'b0000, c_divd_r[d2d_pkg::DIVD_W-1:d2d_pkg::Q_W]} >= c_uden_r;
    d_item_nxt.uden = c_uden_r;
    d_item_nxt.rem  = {4'b0000, c_divd_r[d2d_pkg::DIVD_W-1:d2d_pkg::Q_W]};
    d_item_nxt.dq   = c_divd_r[d2d_pkg::Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (ce) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_d80_r  <= a_d80_nxt;
      b_ok_r   <= b_ok_nxt;
      b_uden_r <= den[d2d_pkg::DEN_W-1:0];
      b_num_r  <= d2d_pkg::NUM_W'(cfg.focal_bl) * d2d_pkg::UNITS_NUM;
      b_divd_r <= cfg.depth_fmt ? {10'b0, d2d_pkg::NUM_W'(cfg.focal_bl) * d2d_pkg::UNITS_NUM}
                                : d2d_pkg::DIVD_W'(cfg.focal_bl) * d2d_pkg::UNITS_MM;
      c_ok_r   <= b_ok_r;
      c_uden_r <= b_uden_r;
      c_num_r  <= b_num_r;
      c_divd_r <= b_divd_r;
      c_prod_r <= d2d_pkg::PROD_W'(cfg.max_depth) * d2d_pkg::PROD_W'(b_uden_r);
      d_item_r <= d_item_nxt;
    end
  end

  assign div_valid = d_v_r;
  assign div_item  = d_item_r;

endmodule

@@ hw/rtl/d2d_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module d2d_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                src_valid,
  input  d2d_pkg::div_item_t  src_item,
  output logic                res_valid,
  output d2d_pkg::div_item_t  res_item
);

  localparam int unsigned NSTG = d2d_pkg::Q_W;

  logic               v_r    [NSTG];
  d2d_pkg::div_item_t item_r [NSTG];
  logic               v_src  [NSTG];
  d2d_pkg::div_item_t i_src  [NSTG];

  assign v_src[0] = src_valid;
  assign i_src[0] = src_item;

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic [d2d_pkg::DEN_W:0] r2;
    logic                    ge;
    d2d_pkg::div_item_t      item_nxt;

    if (g > 0) begin : g_link
      assign v_src[g] = v_r[g-1];
      assign i_src[g] = item_r[g-1];
    end

    always_comb begin
      r2            = {i_src[g].rem, i_src[g].dq[d2d_pkg::Q_W-1]};
      ge            = r2 >= {1'b0, i_src[g].uden};
      item_nxt      = i_src[g];
      item_nxt.rem  = ge ? d2d_pkg::DEN_W'(r2 - {1'b0, i_src[g].uden})
                         : r2[d2d_pkg::DEN_W-1:0];
      item_nxt.dq   = {i_src[g].dq[d2d_pkg::Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (ce) begin
        v_r[g] <= v_src[g];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        item_r[g] <= item_nxt;
      end
    end
  end

  assign res_valid = v_r[NSTG-1];
  assign res_item  = item_r[NSTG-1];

endmodule

@@ hw/rtl/d2d_out.sv @@
// output formatting with output register and skid stage
`timescale 1ns / 1ps

module d2d_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        depth_fmt,
  input  logic                        up_valid,
  input  d2d_pkg::div_item_t          up_item,
  output logic                        up_ready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [d2d_pkg::VAL_W-1:0]   out_tdata,
  output logic                        out_tuser
);

  logic                        o_v_r;
  logic [d2d_pkg::VAL_W-1:0]   o_val_r;
  logic                        o_ok_r;
  logic                        s_v_r;
  logic [d2d_pkg::VAL_W-1:0]   s_val_r;
  logic                        s_ok_r;
  logic [d2d_pkg::VAL_W-1:0]   fmt_val;
  logic                        take;

  always_comb begin
    if (!up_item.ok) begin
      fmt_val = '0;
    end else if (depth_fmt) begin
      fmt_val = up_item.dq;
    end else if (up_item.ovf) begin
      fmt_val = d2d_pkg::MM_SAT;
    end else begin
      fmt_val = {16'b0, up_item.dq[d2d_pkg::Q_W-1:16]};
    end
  end

  assign up_ready = !s_v_r;
  assign take     = !o_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else if (take) begin
      o_v_r <= s_v_r || up_valid;
      s_v_r <= 1'b0;
    end else if (up_valid && !s_v_r) begin
      s_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_val_r <= s_v_r ? s_val_r : fmt_val;
      o_ok_r  <= s_v_r ? s_ok_r : up_item.ok;
    end else if (up_valid && !s_v_r) begin
      s_val_r <= fmt_val;
      s_ok_r  <= up_item.ok;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_val_r;
  assign out_tuser  = o_ok_r;

endmodule

@@ hw/rtl/disparity_to_depth_pixel_core.sv @@
// top level of the disparity to depth pixel core
`timescale 1ns / 1ps

// Takes one raw disparity pixel per clock and returns one depth pixel per clock
// unless the output stalls and fills the skid stage. Pixels pass four front stages
// for scaling, offset removal, the denominator and the depth limit product, then
// the 32-stage restoring divider, one quotient bit per stage, into the output
// register; a skid stage in front of it lets one more pixel complete while a
// result waits. Configuration is to be written through the cfg port only
// while no pixel is in flight; the core itself does not enforce this.

module disparity_to_depth_pixel_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [15:0]                  in_tdata,   // [15:0] raw_disparity
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // [31:0] depth_value
  output logic                         out_tuser,  // [0] depth_valid
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  d2d_pkg::cfg_t      cfg;
  logic               ce;
  logic               front_v;
  d2d_pkg::div_item_t front_item;
  logic               div_v;
  d2d_pkg::div_item_t div_item;

  assign in_tready = ce;

  d2d_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  d2d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_raw    (in_tdata),
    .div_valid (front_v),
    .div_item  (front_item)
  );

  d2d_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .src_valid (front_v),
    .src_item  (front_item),
    .res_valid (div_v),
    .res_item  (div_item)
  );

  d2d_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .depth_fmt  (cfg.depth_fmt),
    .up_valid   (div_v),
    .up_item    (div_item),
    .up_ready   (ce),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ hw/rtl/d2d_checker.sv @@
// port-level checker for the disparity to depth pixel core, with its bind
`timescale 1ns / 1ps

module d2d_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tready,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // invalid pixel carries zero depth
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("invalid pixel with nonzero depth");

  // input back-pressure only while a result waits
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // skid item follows a taken result
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !in_tready |=> out_tvalid && in_tready)
    else $error("skid item not moved to output");

endmodule

bind disparity_to_depth_pixel_core d2d_checker u_chk (.*);

@@ tb/depth_checker.sv @@
// checker for the disparity to depth pixel core: predicts every depth pixel and compares
`timescale 1ns / 1ps

module depth_checker
  import d2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [15:0]        in_tdata,   // [15:0] raw_disparity
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [31:0]        out_tdata,  // [31:0] depth_value
  input  logic               out_tuser,  // [0] depth_valid
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int unsigned MM_PER_M = 1000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             valid;
  } depth_px_t;

  cfg_t      regs;
  depth_px_t expected_px[$];
  int        err_cnt;

  function automatic depth_px_t convert_pixel(input cfg_t c, input logic [RAW_W-1:0] raw);
    depth_px_t         px;
    longint unsigned   d80;
    longint unsigned   d;
    longint unsigned   uden;
    longint unsigned   num;
    longint unsigned   q;
    longint            bias;
    longint            den;
    px = '0;
    if (c.disp_fmt) begin
      d80 = 64'(raw) * 64'(UNITS_16BIT);
    end else begin
      d80 = 64'(raw[7:0]) * 64'(UNITS_8BIT);
    end
    if (c.max_disp > DISP_HIGH_MAX) begin
      d80 = d80 / 64'd10;
    end
    d = (d80 < 64'(c.drv_ofs)) ? 64'd0 : d80 - 64'(c.drv_ofs);
    bias = 64'($signed(c.bias));
    den = longint'(d) + bias;
    if (den > 0 && !(c.ign_zero && d == 64'd0)) begin
      uden = unsigned'(den);
      num = 64'(c.focal_bl) * 64'(UNITS_NUM);
      q = 64'(c.max_depth);
      if (num <= q * uden) begin
        if (!c.depth_fmt) begin
          q = (num * 64'(MM_PER_M)) / (uden * 64'd65536);
          if (q > 64'(MM_SAT)) begin
            q = 64'(MM_SAT);
          end
        end else begin
          q = num / uden;
        end
        px.value = q[VAL_W-1:0];
        px.valid = 1'b1;
      end
    end
    return px;
  endfunction

  always @(posedge clk) begin
    depth_px_t exp_px;
    if (!rst_n) begin
      regs = '0;
      regs.max_disp = RST_MAX_DISP;
      regs.max_depth = RST_MAX_DEPTH;
      expected_px.delete();
      err_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_DISP_FMT:  regs.disp_fmt = cfg_data[0];
          REG_MAX_DISP:  regs.max_disp = cfg_data[MDISP_W-1:0];
          REG_DRV_OFS:   regs.drv_ofs = cfg_data[OFS_W-1:0];
          REG_BIAS:      regs.bias = cfg_data[BIAS_W-1:0];
          REG_FOCAL_BL:  regs.focal_bl = cfg_data[FB_W-1:0];
          REG_MAX_DEPTH: regs.max_depth = cfg_data[MD_W-1:0];
          REG_IGN_ZERO:  regs.ign_zero = cfg_data[0];
          REG_DEPTH_FMT: regs.depth_fmt = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_px.size() == 0) begin
          $display("%0t unexpected depth item: expected none, actual value %h valid %b",
                   $time, out_tdata, out_tuser);
          err_cnt++;
        end else begin
          exp_px = expected_px.pop_front();
          if (out_tdata !== exp_px.value) begin
            $display("%0t depth_value mismatch: expected %h, actual %h",
                     $time, exp_px.value, out_tdata);
            err_cnt++;
          end
          if (out_tuser !== exp_px.valid) begin
            $display("%0t depth_valid mismatch: expected %b, actual %b",
                     $time, exp_px.valid, out_tuser);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_px.push_back(convert_pixel(regs, in_tdata));
      end
    end
    mismatches <= err_cnt;
    outstanding <= expected_px.size();
  end

endmodule

@@ tb/disparity_to_depth_pixel_core_tb.sv @@
// testbench top for the disparity to depth pixel core: stimulus, pacing and verdict
`timescale 1ns / 1ps

module disparity_to_depth_pixel_core_tb;
  import d2d_pkg::*;

  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned RAND_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS    = 85;
  localparam int unsigned QUIET_PHASES   = 2;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata = '0;   // [15:0] raw_disparity
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;       // [31:0] depth_value
  logic               out_tuser;       // [0] depth_valid
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;

  int          mismatches;
  int          outstanding;
  bit          quiet = 1'b0;
  int unsigned idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  disparity_to_depth_pixel_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  depth_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : sink_pacing
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      n = $urandom_range(0, 20);
      repeat (n) @(posedge clk);
    end
  end

  function automatic cfg_t make_settings(input logic fmt, input logic [15:0] maxd,
                                         input logic [19:0] ofs, input int bias,
                                         input logic [31:0] fb, input logic [31:0] md,
                                         input logic ign, input logic dfmt);
    cfg_t s;
    s.disp_fmt  = fmt;
    s.max_disp  = maxd;
    s.drv_ofs   = ofs;
    s.bias      = bias[BIAS_W-1:0];
    s.focal_bl  = fb;
    s.max_depth = md;
    s.ign_zero  = ign;
    s.depth_fmt = dfmt;
    return s;
  endfunction

  function automatic cfg_t rand_settings();
    cfg_t s;
    int   b;
    s.disp_fmt = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0:       s.max_disp = '0;
      1:       s.max_disp = RST_MAX_DISP;
      2:       s.max_disp = DISP_HIGH_MAX;
      3:       s.max_disp = DISP_HIGH_MAX + 16'd1;
      4:       s.max_disp = '1;
      default: s.max_disp = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0, 1:    s.drv_ofs = '0;
      2, 3:    s.drv_ofs = 20'($urandom_range(0, 400));
      4:       s.drv_ofs = 20'($urandom_range(0, 655350));
      default: s.drv_ofs = 20'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0, 1:    b = 0;
      2, 3:    b = int'($urandom_range(0, 400)) - 200;
      4:       b = int'($urandom_range(0, 1310710)) - 655360;
      default: b = int'($urandom);
    endcase
    s.bias = b[BIAS_W-1:0];
    case ($urandom_range(0, 5))
      0:       s.focal_bl = '0;
      1:       s.focal_bl = '1;
      default: s.focal_bl = $urandom >> $urandom_range(0, 20);
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: s.max_depth = '1;
      3:       s.max_depth = '0;
      default: s.max_depth = $urandom >> $urandom_range(0, 24);
    endcase
    s.ign_zero  = 1'($urandom_range(0, 1));
    s.depth_fmt = 1'($urandom_range(0, 1));
    return s;
  endfunction

  function automatic logic [15:0] rand_raw();
    logic [15:0] r;
    case ($urandom_range(0, 7))
      0:       r = 16'($urandom_range(0, 15));
      1:       r = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 7))};
      2: begin
        case ($urandom_range(0, 3))
          0:       r = 16'h0000;
          1:       r = 16'hFFFF;
          2:       r = 16'h00FF;
          default: r = 16'h0100;
        endcase
      end
      default: r = 16'($urandom);
    endcase
    return r;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [CDATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_DISP_FMT,  CDATA_W'(s.disp_fmt));
    write_reg(REG_MAX_DISP,  CDATA_W'(s.max_disp));
    write_reg(REG_DRV_OFS,   CDATA_W'(s.drv_ofs));
    write_reg(REG_BIAS,      {{(CDATA_W-BIAS_W){s.bias[BIAS_W-1]}}, s.bias});
    write_reg(REG_FOCAL_BL,  s.focal_bl);
    write_reg(REG_MAX_DEPTH, s.max_depth);
    write_reg(REG_IGN_ZERO,  CDATA_W'(s.ign_zero));
    write_reg(REG_DEPTH_FMT, CDATA_W'(s.depth_fmt));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [15:0] raw);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero focal baseline
    send_pixel(16'h0000);
    send_pixel(16'd200);
    wait_drained();

    // 8-bit format, millimetres with saturation on near pixels
    apply_settings(make_settings(1'b0, RST_MAX_DISP, 20'd0, 0, 32'h0100_0000,
                                 RST_MAX_DEPTH, 1'b0, 1'b0));
    send_pixel(16'h0000);
    send_pixel(16'h0001);
    send_pixel(16'h00FF);
    send_pixel(16'hFF00);
    send_pixel(16'hFFFF);
    wait_drained();

    // 16-bit format, divide by ten, offset clamp, ignore zero, negative denominator
    apply_settings(make_settings(1'b1, DISP_HIGH_MAX + 16'd1, 20'd100, -50, 32'hFFFF_FFFF,
                                 RST_MAX_DEPTH, 1'b1, 1'b1));
    send_pixel(16'h0000);
    send_pixel(16'd10);
    send_pixel(16'd110);
    send_pixel(16'd1000);
    send_pixel(16'hFFFF);
    wait_drained();

    // largest offset and a large positive bias
    apply_settings(make_settings(1'b1, 16'hFFFF, 20'hFFFFF, 655350, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h0001);
    send_pixel(16'h8000);
    wait_drained();

    // large negative bias, zero depth limit
    apply_settings(make_settings(1'b0, 16'd0, 20'd0, -655360, 32'd1, 32'd0, 1'b0, 1'b0));
    send_pixel(16'h00FF);
    send_pixel(16'h0000);
    wait_drained();

    // depth limit boundary in Q16.16 metres
    apply_settings(make_settings(1'b0, RST_MAX_DISP, 20'd0, 0, 32'h0001_0000,
                                 32'h0000_8000, 1'b0, 1'b1));
    send_pixel(16'd1);
    send_pixel(16'd2);
    send_pixel(16'd3);
    send_pixel(16'd255);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p >= RAND_PHASES - QUIET_PHASES) begin
        quiet = 1'b1;
      end
      apply_settings(rand_settings());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_pixel(rand_raw());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
